FILE: design/tbc_pkg.sv
// shared types and constants of the translation block cache
package tbc_pkg;

  localparam int unsigned TAG_W   = 64;
  localparam int unsigned HDL_W   = 32;
  localparam int unsigned SIZE_W  = 27;
  localparam int unsigned USES_W  = 8;
  localparam int unsigned EV_W    = 7;
  localparam int unsigned CNT32_W = 32;
  localparam int unsigned BYTES_W = 33;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 27;
  localparam int unsigned IN_W  = 128;
  localparam int unsigned OUT_W = 136;

  localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd0;
  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;
  // spare code, changes nothing
  localparam logic [ACT_W-1:0] ACT_NOP    = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd1;

  localparam logic [SIZE_W-1:0] CAPACITY_RESET  = 27'd1048576;
  localparam logic [USES_W-1:0] THRESHOLD_RESET = 8'd3;

  typedef struct packed {
    logic              valid;
    logic [TAG_W-1:0]  tag;
    logic [HDL_W-1:0]  handle;
    logic [SIZE_W-1:0] bytes;
    logic [USES_W-1:0] uses;
    logic              hot;
  } entry_t;

  typedef enum logic [2:0] {
    CC_HOLD,
    CC_CLEAR,
    CC_MTF,
    CC_REMOVE,
    CC_EVICT,
    CC_PUSH
  } cell_cmd_t;

endpackage

FILE: design/tbc_cell.sv
// one cache cell: one entry of the recency ordered list
module tbc_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned AW  = 6
) (
  input  logic                 clk,
  input  logic                 rst,
  input  tbc_pkg::cell_cmd_t   cmd,
  input  logic [AW-1:0]        pos,
  input  logic [63:0]          key,
  input  tbc_pkg::entry_t      new_ent,
  input  tbc_pkg::entry_t      prev_ent,
  input  tbc_pkg::entry_t      next_ent,
  output tbc_pkg::entry_t      ent,
  output logic                 match
);
  import tbc_pkg::*;

  localparam logic [AW-1:0] ME = AW'(IDX);

  assign match = ent.valid && (ent.tag == key);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      ent.hot   <= 1'b0;
    end else begin
      case (cmd)
        CC_CLEAR: begin
          ent.valid <= 1'b0;
          ent.hot   <= 1'b0;
        end
        CC_MTF: begin
          // hit entry to the front, those ahead of it move back one
          if (IDX == 0) ent <= new_ent;
          else if (ME <= pos) ent <= prev_ent;
        end
        CC_REMOVE: begin
          if (ME >= pos) ent <= next_ent;
        end
        CC_EVICT: begin
          if (ME == pos) begin
            ent.valid <= 1'b0;
            ent.hot   <= 1'b0;
          end
        end
        CC_PUSH: begin
          if (IDX == 0) ent <= new_ent;
          else ent <= prev_ent;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: design/translation_block_cache_lru.sv
// top level of the lru translation block cache
//
// Fully associative cache of translated code blocks keyed by guest address.
// Entries sit in a row of cells kept in recency order: cell 0 is the most
// recent, valid entries always fill cells 0 to count-1. Each request steps
// through accept, a register of the tag compares of every cell, resolve, and
// the load of the result register once the master side has room. A clear or
// an unknown action skips the resolve step. An insert evicts entries from the
// tail of the cell row one per cycle while the byte budget is exceeded or the
// row is full, then places the new entry at the front. One request is in
// flight at a time; the next is taken while a finished result still waits
// on the master side. No clearing pass is needed after reset.
module translation_block_cache_lru #(
  parameter int unsigned ENTRIES = 64
) (
  input  logic                                clk,
  input  logic                                rst,
  // slave side, tdata: action, guest_addr, code_handle, code_size, zero pad
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [tbc_pkg::IN_W-1:0]            s_axis_tdata,
  // master side, tdata: hit, out_handle, out_size, hot, evicted_count,
  // lookup_total, miss_total, zero pad
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [tbc_pkg::OUT_W-1:0]           m_axis_tdata,
  // register writes
  input  logic                                cfg_we,
  input  logic [tbc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tbc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import tbc_pkg::*;

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned CW = $clog2(ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MATCH,
    S_RESOLVE,
    S_EVICT,
    S_DONE
  } state_t;

  state_t state;

  // configuration
  logic [SIZE_W-1:0] capacity;
  logic [USES_W-1:0] threshold;

  // latched request
  logic [ACT_W-1:0]  act;
  logic [TAG_W-1:0]  key;
  logic [HDL_W-1:0]  req_handle;
  logic [SIZE_W-1:0] req_size;

  // bookkeeping
  logic [BYTES_W-1:0] bytes_used;
  logic [CW-1:0]      count;
  logic [CNT32_W-1:0] lookup_counter;
  logic [CNT32_W-1:0] miss_counter;
  logic [ENTRIES-1:0] match_q;

  // pending result
  logic              res_hit;
  logic [HDL_W-1:0]  res_handle;
  logic [SIZE_W-1:0] res_size;
  logic              res_hot;
  logic [EV_W-1:0]   res_ev;

  // cell row
  entry_t             ent [ENTRIES];
  logic [ENTRIES-1:0] match_vec;
  logic [ENTRIES-1:0] valid_vec;
  cell_cmd_t          cmd;
  logic [AW-1:0]      cmd_pos;
  entry_t             new_ent;

  genvar gi;
  generate
    for (gi = 0; gi < ENTRIES; gi++) begin : g_cell
      entry_t prev_ent;
      entry_t next_ent;
      if (gi == 0) begin : g_first
        assign prev_ent = '0;
      end else begin : g_mid
        assign prev_ent = ent[gi-1];
      end
      if (gi == ENTRIES - 1) begin : g_last
        assign next_ent = '0;
      end else begin : g_inner
        assign next_ent = ent[gi+1];
      end
      tbc_cell #(.IDX(gi), .AW(AW)) u_cell (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmd),
        .pos      (cmd_pos),
        .key      (key),
        .new_ent  (new_ent),
        .prev_ent (prev_ent),
        .next_ent (next_ent),
        .ent      (ent[gi]),
        .match    (match_vec[gi])
      );
      assign valid_vec[gi] = ent[gi].valid;
    end
  endgenerate

  // one-hot reductions: the matching cell (tags are unique) and the tail cell
  logic               any_hit;
  logic [AW-1:0]      hit_pos;
  entry_t             hit_ent;
  logic [SIZE_W-1:0]  tail_bytes;
  logic [ENTRIES-1:0] tail_vec;

  assign tail_vec = valid_vec & ~(valid_vec >> 1);

  always_comb begin
    any_hit    = |match_q;
    hit_pos    = '0;
    hit_ent    = '0;
    tail_bytes = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match_q[i]) begin
        hit_pos = hit_pos | AW'(i);
        hit_ent = hit_ent | ent[i];
      end
      if (tail_vec[i]) tail_bytes = tail_bytes | ent[i].bytes;
    end
  end

  // use count and hot mark of a hit
  logic [USES_W-1:0] uses_inc;
  logic              hot_upd;
  assign uses_inc = (hit_ent.uses == '1) ? hit_ent.uses : hit_ent.uses + 1'b1;
  assign hot_upd  = hit_ent.hot || (uses_inc >= threshold);

  // eviction condition on the byte budget or a full row
  logic [BYTES_W-1:0] bytes_need;
  logic               need_evict;
  logic [CW-1:0]      count_dec;
  assign bytes_need = bytes_used + BYTES_W'(req_size);
  assign need_evict = (bytes_need > BYTES_W'(capacity)) || (count == CW'(ENTRIES));
  assign count_dec  = count - 1'b1;

  // cell commands for this cycle
  always_comb begin
    cmd     = CC_HOLD;
    cmd_pos = hit_pos;
    new_ent = hit_ent;
    case (state)
      S_MATCH: begin
        if (act == ACT_CLEAR) cmd = CC_CLEAR;
      end
      S_RESOLVE: begin
        if (any_hit && act == ACT_LOOKUP) begin
          cmd          = CC_MTF;
          new_ent.uses = uses_inc;
          new_ent.hot  = hot_upd;
        end else if (any_hit && act == ACT_INSERT) begin
          cmd = CC_REMOVE;
        end
      end
      S_EVICT: begin
        if (need_evict && count != '0) begin
          cmd     = CC_EVICT;
          cmd_pos = count_dec[AW-1:0];
        end else begin
          cmd            = CC_PUSH;
          new_ent.valid  = 1'b1;
          new_ent.tag    = key;
          new_ent.handle = req_handle;
          new_ent.bytes  = req_size;
          new_ent.uses   = USES_W'(1);
          new_ent.hot    = (threshold <= USES_W'(1));
        end
      end
      default: begin
      end
    endcase
  end

  assign s_axis_tready = (state == S_IDLE);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAPACITY_RESET;
      threshold <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CAPACITY:  capacity  <= cfg_data;
        CFG_THRESHOLD: threshold <= cfg_data[USES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // request sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      bytes_used     <= '0;
      count          <= '0;
      lookup_counter <= '0;
      miss_counter   <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      // result register loads when free or emptied in this cycle
      if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act        <= s_axis_tdata[1:0];
            key        <= s_axis_tdata[65:2];
            req_handle <= s_axis_tdata[97:66];
            req_size   <= s_axis_tdata[124:98];
            state      <= S_MATCH;
          end
        end
        S_MATCH: begin
          match_q    <= match_vec;
          res_hit    <= 1'b0;
          res_handle <= '0;
          res_size   <= '0;
          res_hot    <= 1'b0;
          res_ev     <= '0;
          if (act == ACT_CLEAR) begin
            bytes_used     <= '0;
            count          <= '0;
            lookup_counter <= '0;
            miss_counter   <= '0;
            state          <= S_DONE;
          end else if (act == ACT_LOOKUP || act == ACT_INSERT) begin
            state <= S_RESOLVE;
          end else begin
            state <= S_DONE;
          end
        end
        S_RESOLVE: begin
          if (act == ACT_LOOKUP) begin
            if (lookup_counter != '1) lookup_counter <= lookup_counter + 1'b1;
            if (any_hit) begin
              res_hit    <= 1'b1;
              res_handle <= hit_ent.handle;
              res_size   <= hit_ent.bytes;
              res_hot    <= hot_upd;
            end else if (miss_counter != '1) begin
              miss_counter <= miss_counter + 1'b1;
            end
            state <= S_DONE;
          end else begin
            // an insert over a present address frees the old entry first
            if (any_hit) begin
              bytes_used <= bytes_used - BYTES_W'(hit_ent.bytes);
              count      <= count_dec;
            end
            state <= S_EVICT;
          end
        end
        S_EVICT: begin
          if (need_evict && count != '0) begin
            bytes_used <= bytes_used - BYTES_W'(tail_bytes);
            count      <= count_dec;
            if (res_ev != '1) res_ev <= res_ev + 1'b1;
          end else begin
            bytes_used <= bytes_need;
            count      <= count + 1'b1;
            state      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result register, loaded when the result moves to the master side
  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_axis_tvalid || m_axis_tready)) begin
      m_axis_tdata <= {4'b0, miss_counter, lookup_counter, res_ev, res_hot,
                       res_size, res_handle, res_hit};
    end
  end

  // valid entries stay packed at the front of the row
  a_compact: assert property (@(posedge clk) disable iff (rst)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("cell row has a gap");

  // fill count follows the valid cells
  a_count: assert property (@(posedge clk) disable iff (rst)
    32'(count) == 32'($countones(valid_vec)))
    else $error("fill count out of step");

  // at most one valid cell holds the requested tag
  a_unique: assert property (@(posedge clk) disable iff (rst)
    state == S_RESOLVE |-> $onehot0(match_q))
    else $error("several cells match one key");

  // an empty row holds no bytes
  a_bytes: assert property (@(posedge clk) disable iff (rst)
    count == '0 |-> bytes_used == '0)
    else $error("bytes held with no entries");

endmodule
